FILE: design/two_button_short_long_press_classifier_core_macros.svh
// Assertion macros for the two-button press classifier.
// Included by the top level; depends on a clk and rst in scope.
`ifndef TWO_BUTTON_SHORT_LONG_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define TWO_BUTTON_SHORT_LONG_PRESS_CLASSIFIER_CORE_MACROS_SVH

// Condition holds at every edge out of reset.
`define TPBC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Antecedent implies consequent on the following edge.
`define TPBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent on the same edge.
`define TPBC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/tpbc_pkg.sv
// Shared types and constants for the two-button press classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tpbc_pkg;

  localparam int TickW = 7;
  localparam int CodeW = 4;
  localparam int PhaseW = 2;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GUARD = 2'd2;

  localparam logic [TickW-1:0] DEBOUNCE_RESET = 7'd6;
  localparam logic [TickW-1:0] LONG_PRESS_RESET = 7'd30;
  localparam logic [TickW-1:0] GUARD_RESET = 7'd10;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
  localparam logic [PhaseW-1:0] PH_MEASURE = 2'd1;
  localparam logic [PhaseW-1:0] PH_GUARD = 2'd2;

  localparam logic [CodeW-1:0] CODE_A = 4'd7;
  localparam logic [CodeW-1:0] CODE_B = 4'd5;

  localparam logic OP_EVENT = 1'b0;

  typedef struct packed {
    logic [TickW-1:0] debounce_ticks;
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] guard_ticks;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
  } result_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
  } fsm_status_t;

endpackage

FILE: design/tpbc_cfg_regs.sv
// Configuration registers for the press classifier.
// Depends on tpbc_pkg.
`timescale 1ns / 1ps

module tpbc_cfg_regs import tpbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [TickW-1:0]   wr_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
      cfg.guard_ticks <= GUARD_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_DEBOUNCE:   cfg.debounce_ticks <= wr_data;
        CFG_LONG_PRESS: cfg.long_press_ticks <= wr_data;
        CFG_GUARD:      cfg.guard_ticks <= wr_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

FILE: design/tpbc_fsm.sv
// Press qualification state: phase, tick count and pending code.
// Depends on tpbc_pkg; emits at most one result per accepted item.
`timescale 1ns / 1ps

module tpbc_fsm import tpbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        item_en,
  input  logic        op,
  input  logic        pin_a_level,
  input  logic        pin_b_level,
  output result_t     res,
  output fsm_status_t status
);

  logic [PhaseW-1:0] phase, phase_next;
  logic [TickW-1:0]  tick_count, tick_count_next;
  logic [CodeW-1:0]  pending_code, pending_code_next;

  logic              a_low, b_low;
  logic [PhaseW-1:0] phase_cur;
  logic [TickW-1:0]  cnt_inc;

  assign a_low = ~pin_a_level;
  assign b_low = ~pin_b_level;
  assign cnt_inc = tick_count + 7'd1;
  // Unused phase code behaves as idle
  assign phase_cur = (phase == PH_MEASURE || phase == PH_GUARD) ? phase : PH_IDLE;

  always_comb begin
    phase_next = phase_cur;
    tick_count_next = tick_count;
    pending_code_next = pending_code;
    res.valid = 1'b0;
    res.code = pending_code;
    if (op == OP_EVENT) begin
      if (phase_cur == PH_IDLE && (a_low || b_low)) begin
        phase_next = PH_MEASURE;
        tick_count_next = '0;
      end
    end else if (phase_cur == PH_MEASURE) begin
      tick_count_next = cnt_inc;
      priority if (cnt_inc == cfg.debounce_ticks) begin
        priority if (a_low) begin
          pending_code_next = CODE_A;
        end else if (b_low) begin
          pending_code_next = CODE_B;
        end else begin
          phase_next = PH_IDLE;
          tick_count_next = '0;
        end
      end else if (cnt_inc > cfg.debounce_ticks && cnt_inc < cfg.long_press_ticks) begin
        // both released: short press
        if (!a_low && !b_low) begin
          phase_next = PH_GUARD;
          tick_count_next = '0;
        end
      end else if (cnt_inc > cfg.long_press_ticks) begin
        pending_code_next = pending_code + 4'd1;
        phase_next = PH_GUARD;
        tick_count_next = '0;
      end else begin
        // count below debounce count or equal to long-press count: hold
      end
    end else if (phase_cur == PH_GUARD) begin
      tick_count_next = cnt_inc;
      if (cnt_inc > cfg.guard_ticks) begin
        res.valid = 1'b1;
        phase_next = PH_IDLE;
        tick_count_next = '0;
      end
    end
    if (!item_en) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tick_count <= '0;
      pending_code <= '0;
    end else if (item_en) begin
      phase <= phase_next;
      tick_count <= tick_count_next;
      pending_code <= pending_code_next;
    end
  end

  assign status.phase = phase;

endmodule

FILE: design/tpbc_out_buf.sv
// Result register with a skid entry so items keep flowing during a stall.
// Depends on tpbc_pkg.
`timescale 1ns / 1ps

module tpbc_out_buf import tpbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  result_t          res,
  output logic             can_accept,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CodeW-1:0] press_code
);

  logic             skid_valid;
  logic [CodeW-1:0] skid_code;

  assign can_accept = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      // output slot frees: advance skid first, keep order
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= res.valid;
      end else begin
        out_valid <= res.valid;
      end
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        press_code <= skid_code;
        skid_code <= res.code;
      end else begin
        press_code <= res.code;
      end
    end else if (res.valid) begin
      skid_code <= res.code;
    end
  end

endmodule

FILE: design/two_button_short_long_press_classifier_core.sv
// Top level of the two-button short/long press classifier.
// Depends on tpbc_pkg, tpbc_cfg_regs, tpbc_fsm, tpbc_out_buf and the macros header.
`timescale 1ns / 1ps
`include "two_button_short_long_press_classifier_core_macros.svh"

// Usage:
// - Input channel (in_valid/in_ready): one item per pin-change event (op 0) or
//   timer tick (op 1), carrying both active-low pin levels.
// - Output channel (out_valid/out_ready): press_code 5/6 for B short/long,
//   7/8 for A short/long, sent on the guard tick that closes a press.
// - Config channel (cfg_valid/cfg_ready): cfg_index 0 debounce, 1 long press,
//   2 guard; cfg_data is the 7-bit value. Always ready; write only while idle.
// - Each item is processed in the cycle it is accepted; one item per cycle
//   while in_ready is high. A result is registered into the output or skid entry.
// - The output register plus one skid entry decouple the two sides: while
//   the receiver stalls, items keep being accepted until the skid entry
//   fills, then in_ready drops until the receiver takes a result.
// - Reset (rst, synchronous) returns to idle with count and code cleared,
//   restores the register defaults 6, 30 and 10, and empties the output.

module two_button_short_long_press_classifier_core import tpbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic               pin_a_level,
  input  logic               pin_b_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CodeW-1:0]   press_code,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TickW-1:0]   cfg_data
);

  cfg_t        cfg;
  result_t     res;
  fsm_status_t status;
  logic        item_en;

  assign cfg_ready = 1'b1;
  assign item_en = in_valid & in_ready;

  tpbc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tpbc_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_en     (item_en),
    .op          (op),
    .pin_a_level (pin_a_level),
    .pin_b_level (pin_b_level),
    .res         (res),
    .status      (status)
  );

  tpbc_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .press_code (press_code)
  );

  `TPBC_ASSERT_SAME(a_res_from_guard, res.valid, status.phase == PH_GUARD,
    "result raised outside the guard phase")
  `TPBC_ASSERT_SAME(a_full_shows_result, !in_ready, out_valid,
    "skid entry holds an item while the output is empty")
  `TPBC_ASSERT_NEXT(a_emit_goes_idle, res.valid, status.phase == PH_IDLE,
    "block did not return to idle after reporting")
  `TPBC_ASSERT_NEXT(a_result_lands, res.valid, out_valid,
    "accepted result did not reach the output")

endmodule
